// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BCC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("bcc assertion failed");

// Check a property on every clock edge, reset included.
`define BCC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("bcc assertion failed");

`endif

// ===== rtl/core/bcc_pkg.sv =====
package bcc_pkg;

    localparam int DT_WIDTH      = 8;
    localparam int CFG_WIDTH     = 16;
    localparam int BLINK_WIDTH   = 4;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int PHASE_WIDTH   = 5;
    localparam int MAX_PHASES    = 2 * ((1 << BLINK_WIDTH) - 1);
    localparam int DT_MAX        = (1 << DT_WIDTH) - 1;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DBL_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BLINK_HALF  = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BLINK_COUNT = 2'd3;

    localparam logic [CFG_WIDTH-1:0]   RST_DEBOUNCE    = 16'd20;
    localparam logic [CFG_WIDTH-1:0]   RST_DBL_WINDOW  = 16'd400;
    localparam logic [CFG_WIDTH-1:0]   RST_BLINK_HALF  = 16'd100;
    localparam logic [BLINK_WIDTH-1:0] RST_BLINK_COUNT = 4'd3;

    typedef enum logic [1:0] {
        EDGE_NONE   = 2'd0,
        EDGE_FIRST  = 2'd1,
        EDGE_DOUBLE = 2'd2
    } t_edge;

endpackage

// ===== rtl/core/bcc_blink.sv =====
module bcc_blink #(
    parameter int TIME_WIDTH = 16
) (
    input  logic [bcc_pkg::PHASE_WIDTH-1:0] i_phases,
    input  logic [TIME_WIDTH-1:0]           i_phase_ms,
    input  logic [TIME_WIDTH-1:0]           i_half_ms,
    input  logic [bcc_pkg::DT_WIDTH-1:0]    i_dt,
    output logic [bcc_pkg::PHASE_WIDTH-1:0] o_phases,
    output logic [TIME_WIDTH-1:0]           o_phase_ms
);
    import bcc_pkg::*;

    localparam int PW = DT_WIDTH + PHASE_WIDTH;

    logic [TIME_WIDTH-1:0]  dt_ext;
    logic [DT_WIDTH-1:0]    rem_dt;
    logic [DT_WIDTH-1:0]    half_lo;
    logic                   half_big;
    logic [PHASE_WIDTH-1:0] left;
    logic [PHASE_WIDTH-1:0] q;
    logic [DT_WIDTH-1:0]    rest;
    logic [PW-1:0]          mult [MAX_PHASES+1];

    assign dt_ext   = TIME_WIDTH'(i_dt);
    assign rem_dt   = i_dt - i_phase_ms[DT_WIDTH-1:0];
    assign half_lo  = i_half_ms[DT_WIDTH-1:0];
    assign half_big = i_half_ms > TIME_WIDTH'(DT_MAX);
    assign left     = i_phases - PHASE_WIDTH'(1);

    always_comb begin
        for (int j = 0; j <= MAX_PHASES; j++) begin
            mult[j] = PW'(half_lo) * PW'(j);
        end
    end

    // whole phases covered by the time left over
    always_comb begin
        q = '0;
        for (int j = 1; j <= MAX_PHASES; j++) begin
            if (PW'(rem_dt) >= mult[j]) begin
                q = PHASE_WIDTH'(j);
            end
        end
    end

    assign rest = rem_dt - mult[q][DT_WIDTH-1:0];

    always_comb begin
        o_phases   = i_phases;
        o_phase_ms = i_half_ms;
        if (dt_ext < i_phase_ms) begin
            o_phase_ms = i_phase_ms - dt_ext;
        end else if (left == '0 || i_half_ms == '0) begin
            o_phases = '0;
        end else if (half_big) begin
            o_phases   = left;
            o_phase_ms = i_half_ms - TIME_WIDTH'(rem_dt);
        end else if (q >= left) begin
            o_phases = '0;
        end else begin
            o_phases   = left - q;
            o_phase_ms = i_half_ms - TIME_WIDTH'(rest);
        end
    end

endmodule

// ===== rtl/core/button_click_classifier_top.sv =====
// Button click classifier.
// Input channel (i_valid / o_ready): one button sample and the milliseconds
// since the previous sample. Output channel (o_valid / i_ready): one word per
// sample with the LED level, a single-click flag, the edge event code and the
// running single-click total.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 debounce, 1 double-click window, 2 blink half period, 3 blink count)
// at the clock edge; write only while no sample is in flight.
// A sample accepted into the input register has its result on the output
// register once it advances (two register stages: input, result).
// One sample per cycle unless the receiver stalls; all timers, the click classifier and the
// multi-phase blink advance resolve in one pass of logic between the stages.
// Reset clears both stages, the timers, the click state and the count, and
// loads the default register values.
// When the receiver stalls, the result word holds, the input stage keeps one
// more sample and o_ready drops only once both stages are full.
module button_click_classifier_top #(
    parameter int TIME_WIDTH  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bcc_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [bcc_pkg::CFG_WIDTH-1:0]     i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_button_level,
    input  logic [bcc_pkg::DT_WIDTH-1:0]      i_elapsed_ms,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_led_level,
    output logic                              o_single_click,
    output logic [1:0]                        o_edge_event,
    output logic [15:0]                       o_single_total
);
    import bcc_pkg::*;

    logic [CFG_WIDTH-1:0]   r_debounce_ms;
    logic [CFG_WIDTH-1:0]   r_window_ms;
    logic [CFG_WIDTH-1:0]   r_half_ms;
    logic [BLINK_WIDTH-1:0] r_blink_count;

    logic                r_in_valid;
    logic                r_level;
    logic [DT_WIDTH-1:0] r_dt;

    logic                   r_prev_level,   n_prev_level;
    logic [TIME_WIDTH-1:0]  r_debounce_left, n_debounce_left;
    logic [TIME_WIDTH-1:0]  r_window_left,  n_window_left;
    logic                   r_first_pending, n_first_pending;
    logic                   r_toggle,       n_toggle;
    logic [PHASE_WIDTH-1:0] r_phases,       n_phases;
    logic [TIME_WIDTH-1:0]  r_phase_ms,     n_phase_ms;
    logic [COUNT_WIDTH-1:0] r_count,        n_count;

    logic        r_out_valid;
    logic        r_led;
    logic        r_single;
    t_edge       r_edge;
    logic [15:0] r_total;

    logic                   advance;
    logic                   n_single;
    t_edge                  n_edge;
    logic [TIME_WIDTH-1:0]  dt_ext;
    logic [TIME_WIDTH-1:0]  db_dec;
    logic [TIME_WIDTH-1:0]  win_dec;
    logic [TIME_WIDTH-1:0]  half_sat;
    logic [PHASE_WIDTH-1:0] blink_phases;
    logic [TIME_WIDTH-1:0]  blink_phase_ms;

    function automatic logic [TIME_WIDTH-1:0] time_sat(input logic [CFG_WIDTH-1:0] v);
        logic [32:0] wide;
        logic [32:0] tmax;
        wide = 33'(v);
        tmax = (33'(1) << TIME_WIDTH) - 33'(1);
        return (wide > tmax) ? tmax[TIME_WIDTH-1:0] : wide[TIME_WIDTH-1:0];
    endfunction

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= RST_DEBOUNCE;
            r_window_ms   <= RST_DBL_WINDOW;
            r_half_ms     <= RST_BLINK_HALF;
            r_blink_count <= RST_BLINK_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:    r_debounce_ms <= i_cfg_data;
                CFG_DBL_WINDOW:  r_window_ms   <= i_cfg_data;
                CFG_BLINK_HALF:  r_half_ms     <= i_cfg_data;
                CFG_BLINK_COUNT: r_blink_count <= i_cfg_data[BLINK_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_level <= i_button_level;
            r_dt    <= i_elapsed_ms;
        end
    end

    assign dt_ext   = TIME_WIDTH'(r_dt);
    assign db_dec   = (r_debounce_left > dt_ext) ? r_debounce_left - dt_ext : '0;
    assign win_dec  = (r_window_left > dt_ext) ? r_window_left - dt_ext : '0;
    assign half_sat = time_sat(r_half_ms);

    bcc_blink #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_blink (
        .i_phases   (r_phases),
        .i_phase_ms (r_phase_ms),
        .i_half_ms  (half_sat),
        .i_dt       (r_dt),
        .o_phases   (blink_phases),
        .o_phase_ms (blink_phase_ms)
    );

    always_comb begin
        n_prev_level    = r_prev_level;
        n_debounce_left = db_dec;
        n_window_left   = win_dec;
        n_first_pending = r_first_pending;
        n_toggle        = r_toggle;
        n_phases        = r_phases;
        n_phase_ms      = r_phase_ms;
        n_count         = r_count;
        n_single        = 1'b0;
        n_edge          = EDGE_NONE;
        if (r_phases != '0) begin
            n_phases   = blink_phases;
            n_phase_ms = blink_phase_ms;
        end else begin
            if (r_first_pending && win_dec == '0) begin
                n_toggle        = !r_toggle;
                n_count         = r_count + COUNT_WIDTH'(1);
                n_single        = 1'b1;
                n_first_pending = 1'b0;
            end
            if (!r_prev_level && r_level && db_dec == '0) begin
                if (n_first_pending) begin
                    n_edge          = EDGE_DOUBLE;
                    n_first_pending = 1'b0;
                    n_window_left   = '0;
                    n_phases        = {r_blink_count, 1'b0};
                    n_phase_ms      = half_sat;
                end else begin
                    n_edge          = EDGE_FIRST;
                    n_first_pending = 1'b1;
                    n_window_left   = time_sat(r_window_ms);
                end
                n_debounce_left = time_sat(r_debounce_ms);
            end
            n_prev_level = r_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level    <= 1'b0;
            r_debounce_left <= '0;
            r_window_left   <= '0;
            r_first_pending <= 1'b0;
            r_toggle        <= 1'b0;
            r_phases        <= '0;
            r_phase_ms      <= '0;
            r_count         <= '0;
        end else if (advance) begin
            r_prev_level    <= n_prev_level;
            r_debounce_left <= n_debounce_left;
            r_window_left   <= n_window_left;
            r_first_pending <= n_first_pending;
            r_toggle        <= n_toggle;
            r_phases        <= n_phases;
            r_phase_ms      <= n_phase_ms;
            r_count         <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_led    <= (n_phases != '0) ? !n_phases[0] : n_toggle;
            r_single <= n_single;
            r_edge   <= n_edge;
            r_total  <= 16'(32'(n_count));
        end
    end

    assign o_valid        = r_out_valid;
    assign o_led_level    = r_led;
    assign o_single_click = r_single;
    assign o_edge_event   = r_edge;
    assign o_single_total = r_total;

endmodule

// ===== rtl/core/bcc_checker.sv =====
`include "assert_macros.svh"

module bcc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         i_button_level,
    input logic [bcc_pkg::DT_WIDTH-1:0] i_elapsed_ms,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic                         o_led_level,
    input logic                         o_single_click,
    input logic [1:0]                   o_edge_event,
    input logic [15:0]                  o_single_total
);
    import bcc_pkg::*;

    logic [DT_WIDTH:0] in_word;
    logic [19:0]       out_word;

    assign in_word  = {i_button_level, i_elapsed_ms};
    assign out_word = {o_led_level, o_single_click, o_edge_event, o_single_total};

    `BCC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)
    `BCC_ASSERT(a_in_hold, i_clk, i_rst_n, (i_valid && !o_ready) |=> (i_valid && $stable(in_word)))
    `BCC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(out_word)))
    `BCC_ASSERT(a_no_dbl, i_clk, i_rst_n, (o_valid && o_single_click) |-> (o_edge_event != EDGE_DOUBLE))
    `BCC_ASSERT(a_edge_code, i_clk, i_rst_n, o_valid |-> (o_edge_event <= EDGE_DOUBLE))

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (.*);
